// ===== design/srpd_pkg.sv =====
// Shared constants, phase encoding and word types of the SEI recovery point detector.
`default_nettype none
package srpd_pkg;

	// Width of the SEI type, size and accumulation counters
	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Byte counter limits (PES header length sits at byte index 8)
	localparam logic [3:0] SEEN_FULL   = 4'd10;
	localparam logic [3:0] HDR_LEN_IDX = 4'd8;
	localparam logic [3:0] FIRST_LEN   = 4'd2;

	// Byte codes
	localparam logic [7:0] EPB_BYTE     = 8'h03;
	localparam logic [7:0] TRAILER_BYTE = 8'h80;
	localparam logic [7:0] EXT_BYTE     = 8'hff;
	localparam logic [7:0] SC_LAST_BYTE = 8'h01;
	localparam logic [4:0] NAL_SEI      = 5'd6;

	// Register reset
	localparam logic [7:0] WANTED_RESET = 8'd6;

	// Parser phases, one-hot
	typedef enum logic [7:0] {
		PH_FIRST   = 8'b0000_0001,
		PH_HDR     = 8'b0000_0010,
		PH_SEARCH  = 8'b0000_0100,
		PH_NALHDR  = 8'b0000_1000,
		PH_SKIP    = 8'b0001_0000,
		PH_TYPE    = 8'b0010_0000,
		PH_SIZE    = 8'b0100_0000,
		PH_PAYLOAD = 8'b1000_0000
	} phase_t;

	// SEI message parsing state
	typedef struct packed {
		phase_t           phase;
		logic [1:0]       zrun;
		logic [CNT_W-1:0] acc;
		logic [CNT_W-1:0] mtype;
		logic [CNT_W-1:0] left;
		logic             found;
	} sei_st_t;

	// One byte word handed to the parser core
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} srpd_step_t;

	// Result of one payload
	typedef struct packed {
		logic recovery_found;
		logic too_short;
	} srpd_res_t;

endpackage
`default_nettype wire

// ===== design/srpd_ifs.sv =====
// Handshake channel interfaces: byte stream, result and register write.
`default_nettype none
interface srpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface srpd_res_if;
	logic valid;
	logic ready;
	logic recovery_found;
	logic too_short;
	modport source (output valid, output recovery_found, output too_short, input ready);
	modport sink (input valid, input recovery_found, input too_short, output ready);
endinterface

interface srpd_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/sei_recovery_point_detector.sv =====
// Top level: input stage, parser core, result register and register write port.
//
//   channel  dir  word                         when taken
//   stream   in   data_byte, last_byte         valid && ready
//   result   out  recovery_found, too_short    valid && ready, one per payload
//   cfg      in   data (wanted payload type)   valid && ready, always ready
//
// One byte per cycle sustained while no held result stalls a final byte; each byte is
// held in the input stage and then parsed, and a final byte's result is loaded into
// the result register as that byte is parsed, which offers it from there. Reset (arst_n
// low) clears all control state and sets the wanted type to 6. A held result
// stalls only a final byte: other bytes keep flowing while the result waits.
`default_nettype none
module sei_recovery_point_detector (
	input  wire logic clk,
	input  wire logic arst_n,
	srpd_byte_if.sink stream,
	srpd_res_if.source result,
	srpd_cfg_if.sink  cfg
);
	import srpd_pkg::*;

	logic       valid_s1;
	srpd_step_t step_s1;
	logic       adv;
	logic       res_valid_q;
	srpd_res_t  res_q;
	srpd_res_t  core_res;
	logic [7:0] wanted_q;

	// A byte in the input stage moves on unless it is final and the result is held
	assign adv = valid_s1 && (!step_s1.last || !res_valid_q || result.ready);
	assign stream.ready = !valid_s1 || adv;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			step_s1.data <= stream.data_byte;
			step_s1.last <= stream.last_byte;
		end
	end

	// Wanted type register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= WANTED_RESET;
		end else if (cfg.valid) begin
			wanted_q <= cfg.data;
		end
	end

	srpd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.step    (step_s1),
		.wanted  (wanted_q),
		.res     (core_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && step_s1.last) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step_s1.last) res_q <= core_res;
	end

	assign result.valid          = res_valid_q;
	assign result.recovery_found = res_q.recovery_found;
	assign result.too_short      = res_q.too_short;

	// A parsed final byte always leaves a result behind
	a_result_made: assert property (@(posedge clk) disable iff (!arst_n)
		adv && step_s1.last |=> res_valid_q)
		else $error("final byte parsed without result");

	// A short payload never reports a recovery point
	a_short_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.recovery_found && res_q.too_short))
		else $error("short payload flagged as found");

	// A stalled byte keeps its word in the input stage
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(step_s1))
		else $error("input stage lost a stalled byte");

endmodule
`default_nettype wire

// ===== design/srpd_core.sv =====
// Parser core: start code search, header skip, emulation prevention and SEI parsing.
`default_nettype none
module srpd_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step_en,
	input  srpd_pkg::srpd_step_t    step,
	input  wire logic [7:0]         wanted,
	output srpd_pkg::srpd_res_t     res
);
	import srpd_pkg::*;

	// Saturating add of a byte to a counter
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [7:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {{(CNT_W-7){1'b0}}, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

	// One body byte leaves the window: emulation prevention, then SEI fields
	function automatic sei_st_t drain_byte(input sei_st_t s, input logic [7:0] b,
		input logic [7:0] want);
		sei_st_t          r;
		logic             active;
		logic [CNT_W-1:0] sz;
		r = s;
		active = (s.phase == PH_TYPE) || (s.phase == PH_SIZE) || (s.phase == PH_PAYLOAD);
		sz = '0;
		if (active) begin
			if (s.zrun == 2'd2 && b == EPB_BYTE) begin
				r.zrun = 2'd0;
			end else begin
				unique case (s.phase)
					PH_TYPE: begin
						if (s.acc == '0 && b == TRAILER_BYTE) begin
							r.phase = PH_SKIP;
						end else if (b == EXT_BYTE) begin
							r.acc = sat_add(s.acc, EXT_BYTE);
						end else begin
							r.mtype = sat_add(s.acc, b);
							r.acc = '0;
							r.phase = PH_SIZE;
						end
					end
					PH_SIZE: begin
						if (b == EXT_BYTE) begin
							r.acc = sat_add(s.acc, EXT_BYTE);
						end else begin
							sz = sat_add(s.acc, b);
							r.left = sz;
							r.acc = '0;
							if (sz == '0) begin
								if (s.mtype == {{(CNT_W-8){1'b0}}, want}) r.found = 1'b1;
								r.phase = PH_TYPE;
							end else begin
								r.phase = PH_PAYLOAD;
							end
						end
					end
					PH_PAYLOAD: begin
						r.left = s.left - {{(CNT_W-1){1'b0}}, 1'b1};
						if (r.left == '0) begin
							if (s.mtype == {{(CNT_W-8){1'b0}}, want}) r.found = 1'b1;
							r.phase = PH_TYPE;
						end
					end
					default: ;
				endcase
				if (b == 8'h00) r.zrun = (s.zrun == 2'd2) ? 2'd2 : s.zrun + 2'd1;
				else r.zrun = 2'd0;
			end
		end
		return r;
	endfunction

	sei_st_t    st_q, st_n, fl;
	logic [7:0] win_q [3];
	logic [7:0] win_n [3];
	logic [1:0] wcnt_q, wcnt_n;
	logic [3:0] seen_q, seen_n;
	logic [8:0] skip_q, skip_n;
	logic       sc;

	// Next state for one byte, then the flush of the window on the final byte
	always_comb begin
		st_n   = st_q;
		win_n  = win_q;
		wcnt_n = wcnt_q;
		skip_n = skip_q;
		seen_n = (seen_q < SEEN_FULL) ? seen_q + 4'd1 : seen_q;
		// byte completes 00 00 01 with the two newest window bytes
		sc = (step.data == SC_LAST_BYTE) &&
			(((wcnt_q == 2'd2) && win_q[1] == 8'h00 && win_q[0] == 8'h00) ||
			((wcnt_q == 2'd3) && win_q[2] == 8'h00 && win_q[1] == 8'h00));
		unique case (st_q.phase) inside
			PH_FIRST: begin
				if (seen_q < FIRST_LEN) begin
					win_n[wcnt_q] = step.data;
					wcnt_n = wcnt_q + 2'd1;
				end else if (win_q[0] == 8'h00 && win_q[1] == 8'h00 &&
					step.data == SC_LAST_BYTE) begin
					st_n.phase = PH_HDR;
					skip_n = 9'd0;
					wcnt_n = 2'd0;
				end else begin
					st_n.phase = PH_SEARCH;
					win_n[2] = step.data;
					wcnt_n = 2'd3;
				end
			end
			PH_HDR: begin
				if (seen_q == HDR_LEN_IDX) begin
					skip_n = {1'b0, step.data};
				end else if (seen_q > HDR_LEN_IDX) begin
					if (skip_q != 9'd0) begin
						skip_n = skip_q - 9'd1;
					end else begin
						st_n.phase = PH_SEARCH;
						win_n[0] = step.data;
						wcnt_n = 2'd1;
					end
				end
			end
			PH_SEARCH: begin
				if (sc) begin
					st_n.phase = PH_NALHDR;
					wcnt_n = 2'd0;
				end else if (wcnt_q == 2'd3) begin
					win_n[0] = win_q[1];
					win_n[1] = win_q[2];
					win_n[2] = step.data;
				end else begin
					win_n[wcnt_q] = step.data;
					wcnt_n = wcnt_q + 2'd1;
				end
			end
			PH_NALHDR: begin
				st_n.phase = (step.data[4:0] == NAL_SEI) ? PH_TYPE : PH_SKIP;
				st_n.acc = '0;
				st_n.zrun = 2'd0;
				wcnt_n = 2'd0;
			end
			PH_SKIP, PH_TYPE, PH_SIZE, PH_PAYLOAD: begin
				if (sc) begin
					// one zero before 00 00 01 belongs to a four-byte prefix
					if (wcnt_q == 2'd3 && win_q[0] != 8'h00)
						st_n = drain_byte(st_n, win_q[0], wanted);
					st_n.phase = PH_NALHDR;
					wcnt_n = 2'd0;
				end else if (wcnt_q == 2'd3) begin
					st_n = drain_byte(st_n, win_q[0], wanted);
					win_n[0] = win_q[1];
					win_n[1] = win_q[2];
					win_n[2] = step.data;
				end else begin
					win_n[wcnt_q] = step.data;
					wcnt_n = wcnt_q + 2'd1;
				end
			end
			default: ;
		endcase
		// end of payload: the bytes still held in the window are body bytes
		fl = st_n;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < wcnt_n) fl = drain_byte(fl, win_n[i], wanted);
		end
		res.too_short = (seen_n < SEEN_FULL);
		res.recovery_found = !(seen_n < SEEN_FULL) && fl.found;
	end

	// Parser state; everything returns to reset after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '{phase: PH_FIRST, zrun: 2'd0, acc: '0, mtype: '0, left: '0, found: 1'b0};
			win_q  <= '{default: 8'h00};
			wcnt_q <= 2'd0;
			seen_q <= 4'd0;
			skip_q <= 9'd0;
		end else if (step_en) begin
			if (step.last) begin
				st_q   <= '{phase: PH_FIRST, zrun: 2'd0, acc: '0, mtype: '0, left: '0,
					found: 1'b0};
				win_q  <= '{default: 8'h00};
				wcnt_q <= 2'd0;
				seen_q <= 4'd0;
				skip_q <= 9'd0;
			end else begin
				st_q   <= st_n;
				win_q  <= win_n;
				wcnt_q <= wcnt_n;
				seen_q <= seen_n;
				skip_q <= skip_n;
			end
		end
	end

	// Final byte always returns the parser to its start
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && step.last |=> st_q.phase == PH_FIRST && wcnt_q == 2'd0 && seen_q == 4'd0)
		else $error("parser state not cleared after final byte");

	// The first three bytes are always collected before any other phase
	a_first_three: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase != PH_FIRST |-> seen_q >= 4'd3)
		else $error("left first phase before three bytes");

	// While skipping the PES header the window stays empty
	a_hdr_window: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_HDR |-> wcnt_q == 2'd0)
		else $error("window filled during PES header");

endmodule
`default_nettype wire
